// ----- rtl/fractional_n_timer_divider_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks for the fractional-N timer divider. They compile
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_N_TIMER_DIVIDER_CORE_ASSERT_SVH
`define FRACTIONAL_N_TIMER_DIVIDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FNTD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FNTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FNTD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define FNTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/fntd_pkg.sv -----
// ----------------------------------------------------------------------------
// fntd_pkg
// Shared constants, codes and types of the fractional-N timer divider.
// ----------------------------------------------------------------------------
package fntd_pkg;

  // fraction width of the divisor setting
  localparam int FRAC_BITS = 11;
  localparam logic [15:0] FRAC_MOD = 16'(1 << FRAC_BITS);
  localparam logic [31:0] HALF_LSB = 32'(1 << (FRAC_BITS - 1));

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_SLEW  = 2'd2;

  // register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SETTING  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FRACTIME = 8'd3;

  // register reset values
  localparam logic [15:0] NOMINAL_RST = 16'd62500;
  localparam logic [31:0] PERIOD_RST  = 32'd31250000;

  // stream widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_PAD_W  = OUT_DATA_W - 129;

  // divider geometry: 32-bit dividend, 16-bit divisor
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS = 32 / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
    logic [15:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/fntd_div.sv -----
// ----------------------------------------------------------------------------
// fntd_div
// Iterative restoring divider, 32 by 16 bits, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module fntd_div import fntd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          quo;
  logic [15:0]          rem;
  logic [15:0]          dvr;
  logic [16:0]          rem_next;
  logic [31:0]          quo_next;

  // per bit of the step: shift in a dividend bit, subtract if remainder allows
  always_comb begin
    rem_next = {1'b0, rem};
    quo_next = quo;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      rem_next = {rem_next[15:0], quo_next[31]};
      quo_next = {quo_next[30:0], 1'b0};
      if (rem_next >= {1'b0, dvr}) begin
        rem_next    = rem_next - {1'b0, dvr};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvr <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next[15:0];
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ----- rtl/fntd_mul.sv -----
// ----------------------------------------------------------------------------
// fntd_mul
// Shared 32 by 32 multiplier keeping the low 32 product bits, registered.
// ----------------------------------------------------------------------------
module fntd_mul import fntd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [63:0] prod_full;

  assign prod_full = a * b;

  // hold the product while idle so it can be consumed later
  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod_full[31:0];
    end
  end

endmodule

// ----- rtl/fractional_n_timer_divider_core.sv -----
// ----------------------------------------------------------------------------
// fractional_n_timer_divider_core
// Fractional-N timer divider with first-order fraction accumulator and
// timer-count to nanosecond phase conversion.
// ----------------------------------------------------------------------------
// A tick, a slew or an unused action code is handled in the cycle its request
// is accepted, so such requests can stream at one per cycle while the output
// side keeps up. For a phase query the sequencer runs three divisions by the
// effective divisor m through one shared divider that retires two quotient bits
// per cycle (16 steps each) and four products through one shared registered
// multiplier. The input accepts a request only while the sequencer is idle
// and the output register is empty or being drained in the same cycle.
// Configuration writes are always accepted (cfg_ready is tied high);
// indexes beyond the register list are dropped. The effective divisor m is
// taken as 1 whenever it computes to 0.
// ----------------------------------------------------------------------------
`include "fractional_n_timer_divider_core_assert.svh"

module fractional_n_timer_divider_core import fntd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // timer_count[15:0], slew_cycle[31:16]
  input  logic [1:0]             s_axis_tuser,   // action[1:0]
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // next_interval[16:0], phase_ns[48:17],
                                                 // total_ticks[80:49], cycle_count[112:81],
                                                 // sub_cycle[128:113], zero[135:129]
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DIV1   = 4'd1;  // Td / m
  localparam logic [3:0] ST_MUL1   = 4'd2;  // c * Rm
  localparam logic [3:0] ST_MUL2   = 4'd3;  // start (c*Rm + m/2) / m, c * D
  localparam logic [3:0] ST_DIV2   = 4'd4;
  localparam logic [3:0] ST_MUL3   = 4'd5;  // k * c
  localparam logic [3:0] ST_START3 = 4'd6;  // start (k*c) / m
  localparam logic [3:0] ST_DIV3   = 4'd7;
  localparam logic [3:0] ST_MUL4   = 4'd8;  // Tc * sum
  localparam logic [3:0] ST_FIN    = 4'd9;

  // configuration registers
  logic [15:0] nominal_divisor;
  logic [31:0] divisor_setting;
  logic [31:0] period_time_ns;
  logic [31:0] fraction_time_scale;

  // divider state
  logic [15:0] frac_accum;
  logic        bump_flag;
  logic [15:0] sub_cycle_reg;
  logic [31:0] cycle_reg;
  logic [31:0] tick_total;

  // sequencer and datapath
  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [15:0] query_count;
  logic [31:0] time_acc;
  logic [31:0] phase_reg;
  logic        out_valid;

  logic                 in_acc;
  logic [1:0]           action;
  logic [15:0]          timer_count;
  logic [15:0]          slew_cycle;
  logic [15:0]          m_raw;
  logic [15:0]          m_eff;
  logic [FRAC_BITS-1:0] k_val;
  logic [16:0]          next_interval;

  logic [15:0] sub_inc;
  logic [15:0] frac_ret;
  logic [15:0] frac_new;
  logic [31:0] total_new;

  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_p;
  logic [31:0] frac_sum;
  logic [31:0] rnd_sum;
  logic [31:0] delta;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // --------------------------------------------------------------------------
  // Handshakes and field unpacking
  // --------------------------------------------------------------------------
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign action        = s_axis_tuser;
  assign timer_count   = s_axis_tdata[15:0];
  assign slew_cycle    = s_axis_tdata[31:16];

  // --------------------------------------------------------------------------
  // Effective divisor: only the low 16 bits of the whole part matter, so no
  // sign extension past the top of the setting is needed. Force zero to one.
  // --------------------------------------------------------------------------
  assign m_raw         = nominal_divisor + divisor_setting[FRAC_BITS +: 16];
  assign m_eff         = (m_raw == 16'd0) ? 16'd1 : m_raw;
  assign k_val         = divisor_setting[FRAC_BITS-1:0];
  assign next_interval = {1'b0, m_eff} + {16'd0, bump_flag};

  // --------------------------------------------------------------------------
  // Configuration register file
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_divisor     <= NOMINAL_RST;
      divisor_setting     <= '0;
      period_time_ns      <= PERIOD_RST;
      fraction_time_scale <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NOMINAL:  nominal_divisor     <= cfg_data[15:0];
        REG_SETTING:  divisor_setting     <= cfg_data;
        REG_PERIOD:   period_time_ns      <= cfg_data;
        REG_FRACTIME: fraction_time_scale <= cfg_data;
        default: ;  // drop writes beyond the list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tick arithmetic: advance sub-cycle, retire the pending bump, add k
  // --------------------------------------------------------------------------
  assign sub_inc   = sub_cycle_reg + 16'd1;
  assign frac_ret  = bump_flag ? (frac_accum - FRAC_MOD) : frac_accum;
  assign frac_new  = frac_ret + 16'(k_val);
  assign total_new = tick_total + {16'd0, m_eff} + {31'd0, bump_flag};

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_accum    <= '0;
      bump_flag     <= 1'b0;
      sub_cycle_reg <= '0;
      cycle_reg     <= '0;
      tick_total    <= '0;
    end else if (in_acc) begin
      case (action)
        ACT_TICK: begin
          tick_total <= total_new;
          if (sub_inc >= FRAC_MOD) begin
            sub_cycle_reg <= '0;
            cycle_reg     <= cycle_reg + 32'd1;
          end else begin
            sub_cycle_reg <= sub_inc;
          end
          frac_accum <= frac_new;
          bump_flag  <= (frac_new >= FRAC_MOD);
        end
        ACT_SLEW: begin
          sub_cycle_reg <= slew_cycle;
          cycle_reg     <= '0;
          tick_total    <= '0;
        end
        default: ;  // queries and the unused code leave the state alone
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Query sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_acc && (action == ACT_QUERY)) state_next = ST_DIV1;
      ST_DIV1:   if (div_rsp.done) state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_DIV2;
      ST_DIV2:   if (div_rsp.done) state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_START3;
      ST_START3: state_next = ST_DIV3;
      ST_DIV3:   if (div_rsp.done) state_next = ST_MUL4;
      ST_MUL4:   state_next = ST_FIN;
      ST_FIN:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider requests: Td at acceptance, then the rounded remainder product,
  // then k*c. The divisor is always m.
  always_comb begin
    div_req.start    = (in_acc && (action == ACT_QUERY)) ||
                       (state == ST_MUL2) || (state == ST_START3);
    div_req.divisor  = m_eff;
    case (state)
      ST_MUL2:   div_req.dividend = mul_p + {17'd0, m_eff[15:1]};
      ST_START3: div_req.dividend = mul_p;
      default:   div_req.dividend = period_time_ns;
    endcase
  end

  // Multiplier operands per step. In ST_MUL2 the divider still holds D from
  // the first pass; the product c*D then rests in the multiplier during the
  // second division.
  assign frac_sum = {16'd0, frac_accum} + div_rsp.quotient;

  always_comb begin
    mul_en = state inside {ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4};
    case (state)
      ST_MUL1: begin
        mul_a = {16'd0, query_count};
        mul_b = {16'd0, div_rsp.remainder};
      end
      ST_MUL2: begin
        mul_a = {16'd0, query_count};
        mul_b = div_rsp.quotient;
      end
      ST_MUL3: begin
        mul_a = 32'(k_val);
        mul_b = {16'd0, query_count};
      end
      ST_MUL4: begin
        mul_a = fraction_time_scale;
        mul_b = frac_sum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round the correction at half an LSB of the fraction, then drop it
  assign rnd_sum = mul_p + HALF_LSB;
  assign delta   = rnd_sum >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      query_count <= timer_count;
    end
    if ((state == ST_DIV2) && div_rsp.done) begin
      time_acc <= mul_p + div_rsp.quotient;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: phase is held here; the other fields read live state that
  // requests cannot move before the result is taken, but config writes can.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      phase_reg <= '0;
    end else if (state == ST_FIN) begin
      phase_reg <= time_acc - delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((in_acc && (action != ACT_QUERY)) || (state == ST_FIN)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, sub_cycle_reg, cycle_reg, tick_total,
                          phase_reg, next_interval};

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  fntd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  fntd_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `FNTD_ASSERT_IMPLY(a_bump_tracks_accum, clk, rst, 1'b1, bump_flag == (frac_accum >= FRAC_MOD), "bump flag out of step with fraction accumulator")
  `FNTD_ASSERT_IMPLY(a_start_when_free, clk, rst, div_req.start, !div_rsp.busy, "divider started while busy")
  `FNTD_ASSERT_IMPLY(a_idle_div_quiet, clk, rst, state == ST_IDLE, !div_rsp.busy, "divider busy while sequencer idle")
  `FNTD_ASSERT_NEXT(a_fin_gives_result, clk, rst, state == ST_FIN, m_axis_tvalid, "query finished without a result")

endmodule
